FILE: src/assert_macros.svh
// Assertion macros shared by the date adder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset.
`define GDAD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define GDAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define GDAD_ASSERT(lbl, clk, rstn, prop, msg)
`define GDAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: src/gdad_pkg.sv
// Types, constants and calendar functions for the Gregorian date adder.
// Depends on nothing; used by gdad_year_split and gregorian_date_add_days.
package gdad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned REM_W   = 7;

  localparam logic [REM_W-1:0]   CENTURY_YEARS = 7'd100;
  localparam logic [REM_W-1:0]   LAST_OF_CENTURY = 7'd99;
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] day_count;
  } in_item_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               date_valid;
  } out_item_t;

  // Year taken apart as year mod 100 and (year / 100) mod 4.
  typedef struct packed {
    logic [REM_W-1:0] year_mod100;
    logic [1:0]       century_mod4;
  } year_split_t;

  // Leap rule: divisible by 4 but not by 100, or divisible by 400.
  function automatic logic is_leap(logic [1:0] year_lo, year_split_t s);
    logic by100;
    by100 = (s.year_mod100 == '0);
    return ((year_lo == 2'd0) && !by100) || (by100 && (s.century_mod4 == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB:                            len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_SHORT;
      default:                            len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

FILE: src/gdad_year_split.sv
// Split of a year into year mod 100 and century mod 4 by reciprocal multiplication.
// Depends on gdad_pkg; the split is ready when done is raised.
module gdad_year_split (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [gdad_pkg::YEAR_W-1:0] year,
  output logic                 done,
  output gdad_pkg::year_split_t split
);
  import gdad_pkg::*;

  // year * 5243 / 2^19 rounds down to year / 100 for every 14-bit year,
  // because 5243 * 100 exceeds 2^19 by only 12.
  localparam int unsigned        RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam int unsigned        PROD_W      = YEAR_W + RECIP_W;
  localparam int unsigned        QUO_W       = PROD_W - RECIP_SHIFT;

  logic              ld_r, ld_nxt;
  logic              qv_r, qv_nxt;
  logic              done_r, done_nxt;
  logic [YEAR_W-1:0] yr_r, yr_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0] prod;
  logic [YEAR_W-1:0] hundreds;

  assign prod     = PROD_W'(yr_r) * PROD_W'(RECIP_100);
  assign hundreds = YEAR_W'(quo_r) * YEAR_W'(CENTURY_YEARS);

  // The year is latched first, then the quotient is formed, then the remainder.
  always_comb begin
    ld_nxt   = start;
    qv_nxt   = ld_r;
    done_nxt = qv_r;
    yr_nxt   = start ? year : yr_r;
    quo_nxt  = ld_r ? prod[PROD_W-1:RECIP_SHIFT] : quo_r;
    rem_nxt  = qv_r ? REM_W'(yr_r - hundreds) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      qv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ld_r   <= ld_nxt;
      qv_r   <= qv_nxt;
      done_r <= done_nxt;
    end
    yr_r  <= yr_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done               = done_r;
  assign split.year_mod100  = rem_r;
  assign split.century_mod4 = quo_r[1:0];

endmodule

FILE: src/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: sequencer, month stepper, output register.
// Depends on gdad_pkg, gdad_year_split and assert_macros.svh.
//
// Adds an unsigned day count to a Gregorian date and returns the later date
// together with a flag that tells whether the starting date was valid. An
// invalid date (month outside 1..12, day 0, or a day past the end of its
// month) comes back unchanged with date_valid low. Only the low DAY_COUNT_BITS
// bits of day_count are used (all sixteen when the parameter is 16 or more).
// One item is handled at a time: after an input transfer the block first
// splits the year into its remainder and century by a reciprocal
// multiplication, checks the date, then walks forward one month per cycle
// through a single subtract-and-compare unit until the remaining count falls
// inside the current month, and finally loads the output register. A full
// output register that is not drained holds the finished item back. in_ready
// is high only while the sequencer is idle; a finished result may wait in the
// output register while the next item is already taken in. The year counter
// wraps from 16383 to 0 and the leap rule then follows the wrapped year.
module gregorian_date_add_days #(
  parameter int unsigned DAY_COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gdad_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gdad_pkg::out_item_t out_data
);
  import gdad_pkg::*;

  `include "assert_macros.svh"

  // Width of the working count: the used part of the day_count field.
  localparam int unsigned CNT_W = (DAY_COUNT_BITS < COUNT_W) ? DAY_COUNT_BITS : COUNT_W;
  localparam int unsigned LEFT_W = DAY_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_CHECK,
    S_STEP,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [DAY_W-1:0]  day_r, day_nxt;
  logic [MONTH_W-1:0] mon_r, mon_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  year_split_t       split_r, split_nxt;
  logic              ok_r, ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_xfer;
  logic              split_done;
  year_split_t       split_res;
  logic              leap_cur;
  logic [DAY_W-1:0]  dim_cur;
  logic [LEFT_W-1:0] left;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic              date_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  gdad_year_split u_year_split (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .year  (in_data.start_year),
    .done  (split_done),
    .split (split_res)
  );

  // Month length of the date currently held in the working registers.
  assign leap_cur = is_leap(year_r[1:0], split_r);
  assign dim_cur  = month_days(mon_r, leap_cur);

  // The shared unit: days left in this month, counting today, against the count.
  assign left = {1'b0, dim_cur} - {1'b0, day_r} + LEFT_W'(1);
  assign diff = {1'b0, n_r} - (CNT_W + 1)'(left);
  assign fits = diff[CNT_W];

  assign date_ok = (mon_r >= MON_JAN) && (mon_r <= MON_DEC) &&
                   (day_r != '0) && (day_r <= dim_cur);

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    year_nxt      = year_r;
    n_nxt         = n_r;
    split_nxt     = split_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // The consumer drains the output register independently of the sequencer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          day_nxt   = in_data.start_day;
          mon_nxt   = in_data.start_month;
          year_nxt  = in_data.start_year;
          n_nxt     = in_data.day_count[CNT_W-1:0];
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (split_done) begin
          split_nxt = split_res;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ok_nxt    = date_ok;
        state_nxt = date_ok ? S_STEP : S_DONE;
      end
      S_STEP: begin
        if (n_r == '0) begin
          state_nxt = S_DONE;
        end else if (fits) begin
          // The rest of the count lands inside this month.
          day_nxt = day_r + n_r[DAY_W-1:0];
          n_nxt   = '0;
        end else begin
          n_nxt   = diff[CNT_W-1:0];
          day_nxt = DAY_W'(1);
          if (mon_r == MON_DEC) begin
            mon_nxt = MON_JAN;
            if (year_r == '1) begin
              // Wrap of the year counter restarts the split at year zero.
              year_nxt  = '0;
              split_nxt = '0;
            end else begin
              year_nxt = year_r + 1'b1;
              if (split_r.year_mod100 == LAST_OF_CENTURY) begin
                split_nxt.year_mod100  = '0;
                split_nxt.century_mod4 = split_r.century_mod4 + 1'b1;
              end else begin
                split_nxt.year_mod100 = split_r.year_mod100 + 1'b1;
              end
            end
          end else begin
            mon_nxt = mon_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.result_day   = day_r;
          out_data_nxt.result_month = mon_r;
          out_data_nxt.result_year  = year_r;
          out_data_nxt.date_valid   = ok_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    day_r      <= day_nxt;
    mon_r      <= mon_nxt;
    year_r     <= year_nxt;
    n_r        <= n_nxt;
    split_r    <= split_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An input transfer always starts the year split.
  `GDAD_ASSERT_NEXT(a_xfer_starts_split, clk, rst_n, in_xfer, state_r == S_SPLIT, "transfer did not start the year split")

  // While stepping, the working month is a real month.
  `GDAD_ASSERT(a_step_month_range, clk, rst_n, (state_r == S_STEP) |-> ((mon_r >= MON_JAN) && (mon_r <= MON_DEC)), "month out of range while stepping")

  // While stepping, the working day lies inside its month.
  `GDAD_ASSERT(a_step_day_range, clk, rst_n, (state_r == S_STEP) |-> ((day_r != 0) && (day_r <= dim_cur)), "day outside its month while stepping")

  // While stepping, the tracked remainder of the year stays below one century.
  `GDAD_ASSERT(a_split_range, clk, rst_n, (state_r == S_STEP) |-> (split_r.year_mod100 < CENTURY_YEARS), "year remainder out of range")

endmodule

FILE: test/tb.sv
// Self-checking bench for gregorian_date_add_days: random and directed dates go in, and each
// result is compared against a calendar predictor inside this file.
// Depends on gdad_pkg for the transfer structs and the month constants.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  // Day count width given to the block; the predictor masks the count the same way.
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [COUNT_W-1:0] COUNT_MASK =
    (COUNT_BITS >= COUNT_W) ? '1 : ({COUNT_W{1'b1}} >> (COUNT_W - COUNT_BITS));
  localparam int unsigned YEAR_SPAN = 1 << YEAR_W;

  // Run limit. It assumes every item carries the largest count, and it adds room
  // for sender gaps and receiver stalls. That sum is then taken several times over.
  localparam int unsigned CYCLE_LIMIT = 3_500_000;
  // After the last result the bench waits this long, so that any stray extra
  // result would still be seen.
  localparam int unsigned DRAIN_CYCLES = 2400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Items that wait for the driver, and predicted results in transfer order.
  in_item_t    trips_waiting[$];
  out_item_t   due_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idle chances in percent for each side. The stimulus process changes them
  // between phases.
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 77;

  gregorian_date_add_days #(
    .DAY_COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // The plain Gregorian rule, applied to whatever year value the counter holds.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Month length. Month numbers outside 1..12 fall to 31 here; the validity
  // check excludes those months before any length matters.
  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      MON_FEB:                            len = leap_year(y) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      default:                            len = 31;
    endcase
    return len;
  endfunction

  // Predicts the date that is day_count days after the start date. It walks one
  // month at a time, the same way the block does. An invalid start date comes
  // back unchanged with the valid flag low.
  function automatic out_item_t date_after(in_item_t t);
    out_item_t   r;
    int unsigned d, m, y, n, left;
    bit          ok;
    d  = t.start_day;
    m  = t.start_month;
    y  = t.start_year;
    n  = t.day_count & COUNT_MASK;
    ok = (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_length(m, y));
    if (ok) begin
      while (n > 0) begin
        left = month_length(m, y) - d + 1;
        if (n < left) begin
          d += n;
          n = 0;
        end else begin
          n -= left;
          d = 1;
          m++;
          if (m > 12) begin
            // The year counter is 14 bits wide, so it wraps from 16383 to 0.
            m = 1;
            y = (y + 1) % YEAR_SPAN;
          end
        end
      end
    end
    r.result_day   = DAY_W'(d);
    r.result_month = MONTH_W'(m);
    r.result_year  = YEAR_W'(y);
    r.date_valid   = ok;
    return r;
  endfunction

  function automatic in_item_t make_trip(int unsigned d, int unsigned m, int unsigned y,
                                         int unsigned n);
    in_item_t t;
    t.start_day   = DAY_W'(d);
    t.start_month = MONTH_W'(m);
    t.start_year  = YEAR_W'(y);
    t.day_count   = COUNT_W'(n);
    return t;
  endfunction

  // Most random items are valid dates with short counts, so the block stays fast.
  // Years lean toward century boundaries, leap candidates and the top of the year
  // counter. About one item in seven has a large count, some of them near the
  // maximum, which makes the year wrap reachable. A small share gets an
  // out-of-range month or day.
  function automatic in_item_t random_trip();
    int unsigned d, m, y, n, k;
    case ($urandom_range(7))
      0:       y = 100 * $urandom_range(163);
      1:       y = 4 * $urandom_range(4095);
      2:       y = 16383 - $urandom_range(3);
      3:       y = $urandom_range(16383);
      default: y = $urandom_range(9999);
    endcase
    m = ($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(15);
    d = ($urandom_range(99) < 85) ? $urandom_range(month_length(m, y), 1)
                                  : $urandom_range(31);
    k = $urandom_range(99);
    if (k < 60)      n = $urandom_range(60);
    else if (k < 85) n = $urandom_range(1500);
    else if (k < 93) n = $urandom_range(65535);
    else             n = 65535 - $urandom_range(255);
    return make_trip(d, m, y, n);
  endfunction

  // Driver. A new item goes out only when the channel is empty or its current item
  // is transferred at this edge, so valid and the payload stay fixed until the
  // block accepts them. The prediction for an item is queued at its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_dates.push_back(date_after(in_data));
      end
      if (!in_valid || in_ready) begin
        if (trips_waiting.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= trips_waiting.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result transfer is checked against the oldest prediction, one
  // field at a time. The receiver stalls at random through out_ready.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_dates.size() == 0) begin
          $error("result transfer with no prediction waiting: %p", out_data);
          mismatch_count++;
        end else begin
          want = due_dates.pop_front();
          if (out_data.result_day !== want.result_day) begin
            $error("result_day: expected %0d, got %0d", want.result_day,
                   out_data.result_day);
            mismatch_count++;
          end
          if (out_data.result_month !== want.result_month) begin
            $error("result_month: expected %0d, got %0d", want.result_month,
                   out_data.result_month);
            mismatch_count++;
          end
          if (out_data.result_year !== want.result_year) begin
            $error("result_year: expected %0d, got %0d", want.result_year,
                   out_data.result_year);
            mismatch_count++;
          end
          if (out_data.date_valid !== want.date_valid) begin
            $error("date_valid: expected %0b, got %0b", want.date_valid,
                   out_data.date_valid);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog. A hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_item_t directed[$];
    int unsigned phase;

    // Directed items. They cover a zero count, the field extremes, the leap rule at
    // 4, 100 and 400, the year counter wrap and every kind of invalid date.
    directed.push_back(make_trip(1, 1, 0, 0));
    directed.push_back(make_trip(29, 2, 0, 0));          // year 0 is a leap year
    directed.push_back(make_trip(31, 12, 9999, 1));
    directed.push_back(make_trip(31, 12, 16383, 1));     // year counter wraps to 0
    directed.push_back(make_trip(31, 12, 16383, 65535));
    directed.push_back(make_trip(1, 1, 0, 65535));
    directed.push_back(make_trip(28, 2, 1900, 1));       // century, not leap
    directed.push_back(make_trip(28, 2, 2000, 1));       // divisible by 400, leap
    directed.push_back(make_trip(28, 2, 2004, 1));
    directed.push_back(make_trip(29, 2, 2000, 365));
    directed.push_back(make_trip(1, 3, 2100, 0));
    directed.push_back(make_trip(31, 1, 2023, 28));
    directed.push_back(make_trip(30, 6, 2022, 31));
    directed.push_back(make_trip(16, 8, 16380, 40000));
    directed.push_back(make_trip(29, 2, 1900, 5));       // day past a short February
    directed.push_back(make_trip(0, 5, 2020, 10));       // day zero
    directed.push_back(make_trip(31, 4, 2021, 3));       // day past a 30-day month
    directed.push_back(make_trip(15, 0, 2021, 7));       // month zero
    directed.push_back(make_trip(15, 13, 2021, 7));      // month above December
    directed.push_back(make_trip(31, 15, 16383, 65535)); // every bit set, invalid
    directed.push_back(make_trip(30, 2, 2024, 1));       // day past a leap February

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // There are three idle phases: the receiver stalls most, then the sender idles
    // most, then neither side idles. Each phase drains fully before the next
    // one starts. The drain check runs at the falling edge, after the driver and
    // the monitor have settled for the cycle.
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 0) begin
        foreach (directed[i]) trips_waiting.push_back(directed[i]);
        repeat (60) trips_waiting.push_back(random_trip());
      end else begin
        send_idle_pct <= (phase == 1) ? 77 : 0;
        recv_idle_pct <= (phase == 1) ? 11 : 0;
        repeat (85) trips_waiting.push_back(random_trip());
      end
      @(negedge clk);
      while (trips_waiting.size() != 0 || in_valid || due_dates.size() != 0) begin
        @(negedge clk);
      end
    end

    // Give a stray extra result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
